/* design/utf8_class_range_finder_unit_macros.svh */
// Assertion macros used by the checker of the class range finder unit
`ifndef UTF8_CLASS_RANGE_FINDER_UNIT_MACROS_SVH
`define UTF8_CLASS_RANGE_FINDER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset
`define UCRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define UCRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ucrf_pkg.sv */
// Shared types and codes of the class range finder unit
package ucrf_pkg;

    localparam logic [1:0] KIND_SPAN     = 2'd0;
    localparam logic [1:0] KIND_TOTAL    = 2'd1;
    localparam logic [1:0] KIND_INVALID  = 2'd2;
    localparam logic [1:0] KIND_OVERFLOW = 2'd3;

    localparam logic [2:0] REG_MERGE_MODE  = 3'd0;
    localparam logic [2:0] REG_CLASS0_LOW  = 3'd1;
    localparam logic [2:0] REG_CLASS0_HIGH = 3'd2;
    localparam logic [2:0] REG_CLASS1_LOW  = 3'd3;
    localparam logic [2:0] REG_CLASS1_HIGH = 3'd4;
    localparam logic [2:0] REG_CLASS2_LOW  = 3'd5;
    localparam logic [2:0] REG_CLASS2_HIGH = 3'd6;

    localparam int NUM_CLASSES = 3;
    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic                             merge_mode;
        logic [NUM_CLASSES-1:0][20:0]     class_low;
        logic [NUM_CLASSES-1:0][20:0]     class_high;
    } ucrf_cfg_t;

    typedef struct packed {
        logic [31:0] byte_offset;
        logic [31:0] sequence_start;
        logic [20:0] code_accumulator;
        logic [1:0]  bytes_remaining;
        logic [7:0]  lead_byte;
        logic        pending_valid;
        logic [31:0] pending_start;
        logic [31:0] pending_end;
        logic [31:0] matched_count;
        logic        skip_to_end;
    } ucrf_state_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] span_start;
        logic [31:0] span_end;
        logic [31:0] total_matched;
        logic        run_last;
    } ucrf_result_t;

endpackage

/* design/utf8_class_range_finder_unit.sv */
// Output: a byte's results are registered in the result queue and offered on the master side from there.
// Throughput: one byte per cycle while results drain; s_tready falls while the four-entry
// result queue holds more than two results, or two that are not being taken.
// Reset: rst_n is asynchronous; it clears the string state and the result queue and
// returns the class ranges to empty and merge mode to off.
// Top level of the class range finder unit
module utf8_class_range_finder_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] text_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // [31:0] span_start, [63:32] span_end, [95:64] total_matched
    output logic [1:0]   m_tuser,   // [1:0] result_kind
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    ucrf_pkg::ucrf_cfg_t    cfg;
    ucrf_pkg::ucrf_result_t res [ucrf_pkg::MAX_RESULTS];
    ucrf_pkg::ucrf_result_t head;
    logic [1:0]             res_count;
    logic                   accept;
    logic                   can_take;

    assign s_tready = can_take;
    assign accept   = s_tvalid & can_take;

    ucrf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ucrf_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .text_byte  (s_tdata),
        .final_byte (s_tlast),
        .cfg        (cfg),
        .res        (res),
        .res_count  (res_count)
    );

    ucrf_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_count (res_count),
        .push_data  (res),
        .pop        (m_tready),
        .can_take   (can_take),
        .not_empty  (m_tvalid),
        .head       (head)
    );

    assign m_tdata = {head.total_matched, head.span_end, head.span_start};
    assign m_tuser = head.result_kind;
    assign m_tlast = head.run_last;

endmodule

/* design/ucrf_cfg.sv */
// Configuration register file with its APB-style access port
module ucrf_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output ucrf_pkg::ucrf_cfg_t  cfg
);

    ucrf_pkg::ucrf_cfg_t cfg_reg;
    logic                wr_en;
    logic [2:0]          reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel & penable & pwrite;
    assign reg_index = paddr[4:2];
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.merge_mode <= 1'b0;
            for (int i = 0; i < ucrf_pkg::NUM_CLASSES; i++)
            begin
                cfg_reg.class_low[i]  <= 21'd1;
                cfg_reg.class_high[i] <= 21'd0;
            end
        end
        else if (wr_en)
        begin
            case (reg_index)
                ucrf_pkg::REG_MERGE_MODE:  cfg_reg.merge_mode    <= pwdata[0];
                ucrf_pkg::REG_CLASS0_LOW:  cfg_reg.class_low[0]  <= pwdata[20:0];
                ucrf_pkg::REG_CLASS0_HIGH: cfg_reg.class_high[0] <= pwdata[20:0];
                ucrf_pkg::REG_CLASS1_LOW:  cfg_reg.class_low[1]  <= pwdata[20:0];
                ucrf_pkg::REG_CLASS1_HIGH: cfg_reg.class_high[1] <= pwdata[20:0];
                ucrf_pkg::REG_CLASS2_LOW:  cfg_reg.class_low[2]  <= pwdata[20:0];
                ucrf_pkg::REG_CLASS2_HIGH: cfg_reg.class_high[2] <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            ucrf_pkg::REG_MERGE_MODE:  prdata = {31'd0, cfg_reg.merge_mode};
            ucrf_pkg::REG_CLASS0_LOW:  prdata = {11'd0, cfg_reg.class_low[0]};
            ucrf_pkg::REG_CLASS0_HIGH: prdata = {11'd0, cfg_reg.class_high[0]};
            ucrf_pkg::REG_CLASS1_LOW:  prdata = {11'd0, cfg_reg.class_low[1]};
            ucrf_pkg::REG_CLASS1_HIGH: prdata = {11'd0, cfg_reg.class_high[1]};
            ucrf_pkg::REG_CLASS2_LOW:  prdata = {11'd0, cfg_reg.class_low[2]};
            ucrf_pkg::REG_CLASS2_HIGH: prdata = {11'd0, cfg_reg.class_high[2]};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

/* design/ucrf_step.sv */
// String state register and the per-byte decode, class match and span logic
module ucrf_step (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            text_byte,
    input  logic                  final_byte,
    input  ucrf_pkg::ucrf_cfg_t   cfg,
    output ucrf_pkg::ucrf_result_t res [ucrf_pkg::MAX_RESULTS],
    output logic [1:0]            res_count
);

    ucrf_pkg::ucrf_state_t st_reg;
    ucrf_pkg::ucrf_state_t st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (accept)
            st_reg <= st_next;
    end

    always_comb
    begin
        logic [20:0] cp;
        logic        done;
        logic        bad;
        logic        hit;
        logic [31:0] seq_eff;
        logic [31:0] off_inc;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic [2:0]  seq_len;
        logic [2:0]  cp_width;
        logic [1:0]  n;
        logic [20:0] acc_shift;

        st_next   = st_reg;
        cp        = 21'd0;
        done      = 1'b0;
        bad       = 1'b0;
        hit       = 1'b0;
        lo        = 8'h80;
        hi        = 8'hBF;
        n         = 2'd0;
        seq_eff   = (st_reg.bytes_remaining == 2'd0) ? st_reg.byte_offset
                                                     : st_reg.sequence_start;
        off_inc   = st_reg.byte_offset + 32'd1;
        cp_width  = off_inc[2:0] - seq_eff[2:0];
        acc_shift = {st_reg.code_accumulator[14:0], text_byte[5:0]};
        seq_len   = (st_reg.lead_byte >= 8'hF0) ? 3'd4 :
                    (st_reg.lead_byte >= 8'hE0) ? 3'd3 : 3'd2;
        for (int i = 0; i < ucrf_pkg::MAX_RESULTS; i++)
            res[i] = '0;

        if (st_reg.skip_to_end)
        begin
            if (final_byte)
                st_next = '0;
        end
        else if (st_reg.byte_offset == 32'hFFFF_FFFF)
        begin
            res[0] = '{ucrf_pkg::KIND_OVERFLOW, st_reg.sequence_start,
                       st_reg.byte_offset, 32'd0, 1'b0};
            n = 2'd1;
            st_next = '0;
            st_next.skip_to_end = !final_byte;
        end
        else
        begin
            if (st_reg.bytes_remaining == 2'd0)
            begin
                st_next.sequence_start = st_reg.byte_offset;
                st_next.lead_byte      = text_byte;
                if (text_byte < 8'h80)
                begin
                    cp   = {13'd0, text_byte};
                    done = 1'b1;
                end
                else if (text_byte inside {[8'hC2:8'hDF]})
                begin
                    st_next.code_accumulator = {16'd0, text_byte[4:0]};
                    st_next.bytes_remaining  = 2'd1;
                end
                else if (text_byte inside {[8'hE0:8'hEF]})
                begin
                    st_next.code_accumulator = {17'd0, text_byte[3:0]};
                    st_next.bytes_remaining  = 2'd2;
                end
                else if (text_byte inside {[8'hF0:8'hF4]})
                begin
                    st_next.code_accumulator = {18'd0, text_byte[2:0]};
                    st_next.bytes_remaining  = 2'd3;
                end
                else
                    bad = 1'b1;
            end
            else
            begin
                if ({1'b0, st_reg.bytes_remaining} == seq_len - 3'd1)
                begin
                    case (st_reg.lead_byte)
                        8'hE0:   lo = 8'hA0;
                        8'hED:   hi = 8'h9F;
                        8'hF0:   lo = 8'h90;
                        8'hF4:   hi = 8'h8F;
                        default: ;
                    endcase
                end
                if (text_byte < lo || text_byte > hi)
                    bad = 1'b1;
                else
                begin
                    st_next.code_accumulator = acc_shift;
                    st_next.bytes_remaining  = st_reg.bytes_remaining - 2'd1;
                    if (st_next.bytes_remaining == 2'd0)
                    begin
                        cp   = acc_shift;
                        done = 1'b1;
                    end
                end
            end

            if (bad || (final_byte && !done && st_next.bytes_remaining != 2'd0))
            begin
                res[0] = '{ucrf_pkg::KIND_INVALID, seq_eff, st_reg.byte_offset,
                           32'd0, 1'b0};
                n = 2'd1;
                st_next = '0;
                st_next.skip_to_end = !final_byte;
            end
            else
            begin
                st_next.byte_offset = off_inc;
                for (int i = 0; i < ucrf_pkg::NUM_CLASSES; i++)
                    if (cfg.class_low[i] <= cp && cp <= cfg.class_high[i])
                        hit = 1'b1;

                if (done && hit)
                begin
                    st_next.matched_count = st_reg.matched_count + {29'd0, cp_width};
                    if (st_reg.pending_valid && cfg.merge_mode &&
                        st_reg.pending_end == seq_eff)
                        st_next.pending_end = off_inc;
                    else
                    begin
                        if (st_reg.pending_valid)
                        begin
                            res[n] = '{ucrf_pkg::KIND_SPAN, st_reg.pending_start,
                                       st_reg.pending_end, 32'd0, 1'b0};
                            n = n + 2'd1;
                        end
                        st_next.pending_valid = 1'b1;
                        st_next.pending_start = seq_eff;
                        st_next.pending_end   = off_inc;
                    end
                end

                if (final_byte)
                begin
                    if (st_next.pending_valid)
                    begin
                        res[n] = '{ucrf_pkg::KIND_SPAN, st_next.pending_start,
                                   st_next.pending_end, 32'd0, 1'b0};
                        n = n + 2'd1;
                    end
                    res[n] = '{ucrf_pkg::KIND_TOTAL, 32'd0, off_inc,
                               st_next.matched_count, 1'b0};
                    n = n + 2'd1;
                    st_next = '0;
                end
            end
        end

        for (int i = 0; i < ucrf_pkg::MAX_RESULTS; i++)
            res[i].run_last = (n != 2'd0) && (2'(i) == n - 2'd1);
        res_count = n;
    end

endmodule

/* design/ucrf_fifo.sv */
// Four-entry result queue taking up to three results per beat
module ucrf_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [1:0]             push_count,
    input  ucrf_pkg::ucrf_result_t push_data [ucrf_pkg::MAX_RESULTS],
    input  logic                   pop,
    output logic                   can_take,
    output logic                   not_empty,
    output ucrf_pkg::ucrf_result_t head
);

    ucrf_pkg::ucrf_result_t mem_reg [4];
    logic [1:0]             wr_ptr_reg;
    logic [1:0]             rd_ptr_reg;
    logic [2:0]             count_reg;
    logic [1:0]             push_n;
    logic                   pop_en;

    assign not_empty = (count_reg != 3'd0);
    assign pop_en    = pop & not_empty;
    assign can_take  = (count_reg <= 3'd1) || (count_reg == 3'd2 && pop_en);
    assign push_n    = push ? push_count : 2'd0;
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ucrf_pkg::MAX_RESULTS; i++)
            if (2'(i) < push_n)
                mem_reg[wr_ptr_reg + 2'(i)] <= push_data[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop_en};
            count_reg  <= count_reg + {1'b0, push_n} - {2'd0, pop_en};
        end
    end

endmodule

/* design/ucrf_checker.sv */
// Port-level checker of the class range finder unit and its bind
`include "utf8_class_range_finder_unit_macros.svh"

module ucrf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    `UCRF_ASSERT_NEXT(a_hold_stalled, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result beat changed")
    `UCRF_ASSERT_NOW(a_span_nonempty, clk, rst_n, m_tvalid && m_tuser == ucrf_pkg::KIND_SPAN, m_tdata[63:32] > m_tdata[31:0], "span beat with end not past start")
    `UCRF_ASSERT_NOW(a_total_only, clk, rst_n, m_tvalid && m_tuser != ucrf_pkg::KIND_TOTAL, m_tdata[95:64] == 32'd0, "matched total on a non-total beat")
    `UCRF_ASSERT_NOW(a_end_is_last, clk, rst_n, m_tvalid && m_tuser != ucrf_pkg::KIND_SPAN, m_tlast, "total or error beat without tlast")

endmodule

bind utf8_class_range_finder_unit ucrf_checker u_ucrf_checker (.*);
